/* rtl/tsa_pkg.sv */
// Shared types, constants and helpers for the time series aggregator.
// No dependencies; imported by every module of the block.
`default_nettype none

package tsa_pkg;

	localparam int VALUE_WIDTH = 48;
	localparam int COUNT_WIDTH = 32;
	localparam int SUM_WIDTH   = 64;
	localparam int TIME_WIDTH  = 64;
	localparam int OUT_COUNT_W = 32;
	localparam int MODE_WIDTH  = 3;
	localparam int DIV_CNT_W   = $clog2(SUM_WIDTH);

	typedef enum logic [MODE_WIDTH-1:0] {
		MODE_COUNT = 3'd0,
		MODE_SUM   = 3'd1,
		MODE_AVG   = 3'd2,
		MODE_MIN   = 3'd3,
		MODE_MAX   = 3'd4,
		MODE_FIRST = 3'd5,
		MODE_LAST  = 3'd6,
		MODE_NONE  = 3'd7
	} agg_mode_t;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef struct packed {
		logic signed [TIME_WIDTH-1:0]  point_time;
		logic signed [VALUE_WIDTH-1:0] point_value;
		logic                          has_value;
		logic                          last_point;
	} point_t;

	typedef struct packed {
		logic signed [SUM_WIDTH-1:0]  agg_value;
		logic [OUT_COUNT_W-1:0]       set_count;
		logic signed [TIME_WIDTH-1:0] agg_time;
		logic                         no_value;
		logic                         sum_saturated;
	} result_t;

	typedef struct packed {
		logic signed [SUM_WIDTH-1:0] y;
		logic                        neg;
		logic                        ovf;
	} alu_res_t;

	typedef struct packed {
		logic idle;
		logic res_valid;
	} core_sts_t;

	function automatic logic signed [SUM_WIDTH-1:0] sext_value(
		input logic signed [VALUE_WIDTH-1:0] v);
		return SUM_WIDTH'(v);
	endfunction

	// point tally clamped to the 32-bit output field
	function automatic logic [OUT_COUNT_W-1:0] sat_count(input logic [COUNT_WIDTH-1:0] c);
		logic [63:0] w;
		w = 64'(c);
		return (w > 64'hFFFF_FFFF) ? '1 : w[OUT_COUNT_W-1:0];
	endfunction

endpackage

`default_nettype wire

/* rtl/time_series_aggregator.sv */
// Top level of the time series aggregator: ports, mode register, result register.
// Depends on tsa_pkg and tsa_core (which holds tsa_alu).
`default_nettype none

// Streaming aggregate over one query result set. Points come in on the
// point channel in delivery order; the point flagged last_point closes the
// set and yields exactly one result item on the result channel, chosen by
// the 3-bit mode register (count, sum, average, min, max, first, last, none).
// Values are signed Q31.16 in 48 bits; the running sum is 64 bits and clamps
// at the signed limits, which sum_saturated reports for the whole set.
// Average is the clamped sum over all points of the set, truncated toward
// zero. The sum, extreme compare and divide arithmetic goes through one
// 64-bit add/subtract unit under a small sequencer, so point_stall is high
// while an item is being worked on: a point without a value is only
// accepted, a point with a value also takes a sum update and an extreme
// compare. The last point then builds the result, in average mode also
// through a 64-step restoring divide and a sign fix on the same unit, and
// waits until the output register takes it. The output register lets the
// result wait on result_stall while the next set already streams in;
// only a second result has to wait for it to drain. No clearing pass
// after reset. The mode register takes a write whenever the sequencer is
// idle (cfg_ready high); a write inside an open set steers how later valued
// points update the extreme and picks the aggregate the set closes with.
module time_series_aggregator
	import tsa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [MODE_WIDTH-1:0] cfg_data,
	input  logic                  point_valid,
	output logic                  point_stall,
	input  point_t                point,
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_t               result
);

	agg_mode_t mode_q;
	logic      out_valid_q;
	result_t   result_q;
	core_sts_t sts;
	result_t   core_res;
	logic      res_take;

	// core result moves into the output register when that is empty or draining
	assign res_take = sts.res_valid && (!out_valid_q || !result_stall);

	tsa_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.mode    (mode_q),
		.pt_valid(point_valid),
		.pt      (point),
		.res_take(res_take),
		.sts     (sts),
		.res     (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_COUNT;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mode_q <= agg_mode_t'(cfg_data);
			end
			if (res_take) begin
				result_q    <= core_res;
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign cfg_ready    = sts.idle;
	assign point_stall  = !sts.idle;
	assign result_valid = out_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

/* rtl/tsa_alu.sv */
// Shared 64-bit add/subtract unit: saturating add, and subtract with a sign out.
// Depends on tsa_pkg.
`default_nettype none

module tsa_alu
	import tsa_pkg::*;
(
	input  alu_op_t                     op,
	input  logic signed [SUM_WIDTH-1:0] a,
	input  logic signed [SUM_WIDTH-1:0] b,
	output alu_res_t                    res
);

	logic signed [SUM_WIDTH:0] a_x;
	logic signed [SUM_WIDTH:0] b_x;
	logic signed [SUM_WIDTH:0] r_x;
	logic                      ovf;

	assign a_x = (SUM_WIDTH+1)'(a);
	assign b_x = (SUM_WIDTH+1)'(b);
	assign r_x = (op == ALU_SUB) ? (a_x - b_x) : (a_x + b_x);
	assign ovf = r_x[SUM_WIDTH] ^ r_x[SUM_WIDTH-1];

	always_comb begin
		res.neg = r_x[SUM_WIDTH];
		res.ovf = (op == ALU_ADD) && ovf;
		if ((op == ALU_ADD) && ovf) begin
			// clamp to the signed limit on the side the true sum went
			res.y = r_x[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
			                       : {1'b0, {(SUM_WIDTH-1){1'b1}}};
		end else begin
			res.y = r_x[SUM_WIDTH-1:0];
		end
	end

endmodule

`default_nettype wire

/* rtl/tsa_core.sv */
// Accumulator state and sequencer of the aggregator; drives the shared ALU,
// including the restoring divide for average. Depends on tsa_pkg, tsa_alu.
`default_nettype none

module tsa_core
	import tsa_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  agg_mode_t mode,
	input  logic      pt_valid,
	input  point_t    pt,
	input  logic      res_take,
	output core_sts_t sts,
	output result_t   res
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SUM,
		S_EXT,
		S_FIN,
		S_DIV,
		S_SGN,
		S_DONE
	} state_t;

	state_t                         state_q;
	point_t                         pt_q;
	logic signed [SUM_WIDTH-1:0]    sum_q;
	logic signed [VALUE_WIDTH-1:0]  ext_q;
	logic                           saw_q;
	logic [COUNT_WIDTH-1:0]         tally_q;
	logic signed [VALUE_WIDTH-1:0]  first_val_q;
	logic signed [TIME_WIDTH-1:0]   first_time_q;
	logic                           start_q;
	logic                           ovf_q;
	logic [SUM_WIDTH-1:0]           dvd_q;
	logic [COUNT_WIDTH-1:0]         rem_q;
	logic [DIV_CNT_W-1:0]           cnt_q;
	logic                           neg_q;
	result_t                        res_q;

	alu_op_t                        alu_op;
	logic signed [SUM_WIDTH-1:0]    alu_a;
	logic signed [SUM_WIDTH-1:0]    alu_b;
	alu_res_t                       alu;
	logic [COUNT_WIDTH:0]           rem_sh;
	logic [COUNT_WIDTH-1:0]         tally_nxt;
	result_t                        fin_res;

	tsa_alu u_alu (
		.op (alu_op),
		.a  (alu_a),
		.b  (alu_b),
		.res(alu)
	);

	assign rem_sh    = {rem_q, dvd_q[SUM_WIDTH-1]};
	assign tally_nxt = start_q ? COUNT_WIDTH'(1)
	                 : ((&tally_q) ? tally_q : tally_q + COUNT_WIDTH'(1));

	always_comb begin
		alu_op = ALU_ADD;
		alu_a  = '0;
		alu_b  = '0;
		case (state_q)
			S_SUM: begin
				alu_a = sum_q;
				alu_b = sext_value(pt_q.point_value);
			end
			S_EXT: begin
				alu_op = ALU_SUB;
				if (mode == MODE_MAX) begin
					alu_a = sext_value(ext_q);
					alu_b = sext_value(pt_q.point_value);
				end else begin
					alu_a = sext_value(pt_q.point_value);
					alu_b = sext_value(ext_q);
				end
			end
			S_FIN: begin
				alu_op = ALU_SUB;
				alu_b  = sum_q;
			end
			S_DIV: begin
				alu_op = ALU_SUB;
				alu_a  = SUM_WIDTH'(rem_sh);
				alu_b  = SUM_WIDTH'(tally_q);
			end
			S_SGN: begin
				alu_op = ALU_SUB;
				alu_b  = dvd_q;
			end
			default: begin
				alu_op = ALU_ADD;
			end
		endcase
	end

	always_comb begin
		fin_res               = '0;
		fin_res.set_count     = sat_count(tally_q);
		fin_res.sum_saturated = ovf_q;
		case (mode)
			MODE_COUNT: fin_res.agg_value = SUM_WIDTH'(tally_q);
			MODE_SUM:   fin_res.agg_value = sum_q;
			MODE_MIN, MODE_MAX: begin
				if (saw_q) begin
					fin_res.agg_value = sext_value(ext_q);
				end else begin
					fin_res.no_value = 1'b1;
				end
			end
			MODE_FIRST: begin
				fin_res.agg_value = sext_value(first_val_q);
				fin_res.agg_time  = first_time_q;
			end
			MODE_LAST: begin
				if (pt_q.has_value) begin
					fin_res.agg_value = sext_value(pt_q.point_value);
					fin_res.agg_time  = pt_q.point_time;
				end
			end
			default: fin_res.agg_value = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			sum_q        <= '0;
			ext_q        <= '0;
			saw_q        <= 1'b0;
			tally_q      <= '0;
			first_val_q  <= '0;
			first_time_q <= '0;
			start_q      <= 1'b1;
			ovf_q        <= 1'b0;
			cnt_q        <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (pt_valid) begin
						pt_q    <= pt;
						tally_q <= tally_nxt;
						if (start_q) begin
							// new set: drop everything from the previous one
							sum_q        <= '0;
							ext_q        <= '0;
							saw_q        <= 1'b0;
							ovf_q        <= 1'b0;
							first_val_q  <= pt.has_value ? pt.point_value : '0;
							first_time_q <= pt.has_value ? pt.point_time : '0;
							start_q      <= 1'b0;
						end
						if (pt.has_value) begin
							state_q <= S_SUM;
						end else if (pt.last_point) begin
							state_q <= S_FIN;
						end
					end
				end
				S_SUM: begin
					sum_q   <= alu.y;
					ovf_q   <= ovf_q | alu.ovf;
					state_q <= S_EXT;
				end
				S_EXT: begin
					if (!saw_q || alu.neg) begin
						ext_q <= pt_q.point_value;
					end
					saw_q   <= 1'b1;
					state_q <= pt_q.last_point ? S_FIN : S_IDLE;
				end
				S_FIN: begin
					res_q   <= fin_res;
					start_q <= 1'b1;
					if (mode == MODE_AVG) begin
						// divide the magnitude, fix the sign afterwards
						dvd_q   <= sum_q[SUM_WIDTH-1] ? alu.y : sum_q;
						neg_q   <= sum_q[SUM_WIDTH-1];
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= S_DIV;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DIV: begin
					rem_q <= alu.neg ? rem_sh[COUNT_WIDTH-1:0] : alu.y[COUNT_WIDTH-1:0];
					dvd_q <= {dvd_q[SUM_WIDTH-2:0], ~alu.neg};
					cnt_q <= cnt_q + DIV_CNT_W'(1);
					if (cnt_q == DIV_CNT_W'(SUM_WIDTH-1)) begin
						state_q <= S_SGN;
					end
				end
				S_SGN: begin
					res_q.agg_value <= neg_q ? alu.y : dvd_q;
					state_q         <= S_DONE;
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign sts.idle      = (state_q == S_IDLE);
	assign sts.res_valid = (state_q == S_DONE);
	assign res           = res_q;

endmodule

`default_nettype wire

/* rtl/tsa_checker.sv */
// Port-level checks for the time series aggregator, bound to the top level.
// Depends on tsa_pkg.
`default_nettype none

module tsa_checker
	import tsa_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cfg_valid,
	input logic                  cfg_ready,
	input logic [MODE_WIDTH-1:0] cfg_data,
	input logic                  point_valid,
	input logic                  point_stall,
	input point_t                point,
	input logic                  result_valid,
	input logic                  result_stall,
	input result_t               result
);

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// a valued point always needs the sum and extreme steps
	a_valued_busy: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && !point_stall && point.has_value |=> point_stall)
		else $error("valued point did not occupy the sequencer");

	// min/max without values gives zero value and zero time
	a_no_value: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.no_value |-> result.agg_value == 0 && result.agg_time == 0)
		else $error("no_value result carries data");

	// every set holds at least its last point
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.set_count != 0)
		else $error("result with empty set count");

endmodule

bind time_series_aggregator tsa_checker u_tsa_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cfg_valid   (cfg_valid),
	.cfg_ready   (cfg_ready),
	.cfg_data    (cfg_data),
	.point_valid (point_valid),
	.point_stall (point_stall),
	.point       (point),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.result      (result)
);

`default_nettype wire
